/* hw/rtl/sacl_pkg.sv */
// Shared types, constants and codes of the set-associative cache lookup.
`default_nettype none
package sacl_pkg;

    localparam int MAX_SETS  = 256;
    localparam int MAX_WAYS  = 16;
    localparam int ADDR_W    = 32;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int WAYC_W    = $clog2(MAX_WAYS + 1);

    // Field widths of the channels and registers
    localparam int OUTC_W    = 2;
    localparam int OUTWAY_W  = 4;
    localparam int SETB_W    = 4;
    localparam int OFFB_W    = 4;
    localparam int WAYS_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

    localparam logic [SETB_W-1:0] SET_BITS_RST    = 4'd4;
    localparam logic [OFFB_W-1:0] OFFSET_BITS_RST = 4'd3;
    localparam logic [WAYS_W-1:0] WAYS_RST        = 5'd8;

    // Access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OC_READ_HIT   = 2'd0;
    localparam logic [OUTC_W-1:0] OC_WRITE_HIT  = 2'd1;
    localparam logic [OUTC_W-1:0] OC_READ_MISS  = 2'd2;
    localparam logic [OUTC_W-1:0] OC_WRITE_MISS = 2'd3;

    typedef logic [MAX_WAYS-1:0][ADDR_W-1:0] t_tag_arr;

    // Per-set state: line valid bits and round-robin victim pointer
    typedef struct packed {
        logic [MAX_WAYS-1:0] valid;
        logic [WAY_W-1:0]    ptr;
    } t_meta;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        t_meta            meta_next;
    } t_match;

endpackage
`default_nettype wire

/* hw/rtl/sacl_if.sv */
// Request and response channel interfaces of the cache lookup.
`default_nettype none
interface sacl_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [sacl_pkg::ADDR_W-1:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

interface sacl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sacl_pkg::OUTC_W-1:0]   outcome;
    logic [sacl_pkg::OUTWAY_W-1:0] way_used;

    modport source (output valid, output outcome, output way_used, input ready);
    modport sink   (input valid, input outcome, input way_used, output ready);
endinterface
`default_nettype wire

/* hw/rtl/set_assoc_cache_lookup.sv */
// Top level of the set-associative cache lookup with round-robin replacement.
//
//  channel   dir  handshake            payload
//  i_req     in   valid/ready          mode, address
//  o_rsp     out  valid/ready          outcome, way_used
//  i_cfg_*   in   write enable only    idx, data
//
// One request a cycle while the response is not stalled. Tag and state RAM are read
// on the accepting edge into the compare stage; compare and fill then go into the
// output register. The per-set state RAM is read, then rewritten by the fill; a
// one-entry bypass of the last fill covers back-to-back requests to one set.
// Reset takes effect at once: per-set flags mark untouched sets, no sweep.
// A stalled response holds the compare stage, and then the request side.
`default_nettype none
module set_assoc_cache_lookup (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    sacl_req_if.sink                                i_req,
    sacl_rsp_if.source                              o_rsp,
    input  wire logic                               i_cfg_we,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sacl_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import sacl_pkg::*;

    // configuration
    logic [SETB_W-1:0] r_set_bits;
    logic [OFFB_W-1:0] r_offset_bits;
    logic [WAYS_W-1:0] r_ways;
    logic [WAYC_W-1:0] ways_act;

    // request decode
    logic              req_acc;
    logic [ADDR_W-1:0] req_block;
    logic [SET_W-1:0]  set_mask;
    logic [SET_W-1:0]  req_set;

    // compare stage
    logic              r_s1_valid;
    logic              r_s1_mode;
    logic [ADDR_W-1:0] r_s1_block;
    logic [SET_W-1:0]  r_s1_set;
    logic              s1_adv;
    logic              s1_fire;

    // state read, bypass and per-set flags
    t_tag_arr          tag_rd;
    t_tag_arr          tag_eff;
    t_meta             meta_rd;
    t_meta             meta_eff;
    logic              fw_hit;
    logic              r_fw_valid;
    logic [SET_W-1:0]  r_fw_set;
    logic [WAY_W-1:0]  r_fw_way;
    logic [ADDR_W-1:0] r_fw_tag;
    t_meta             r_fw_meta;
    logic [MAX_SETS-1:0] r_touched;
    logic              fill;
    t_match            m;

    // response register
    logic                r_out_valid;
    logic [OUTC_W-1:0]   r_out_outcome;
    logic [OUTWAY_W-1:0] r_out_way;
    logic [OUTC_W-1:0]   n_outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= SET_BITS_RST;
            r_offset_bits <= OFFSET_BITS_RST;
            r_ways        <= WAYS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SET_BITS:    r_set_bits    <= i_cfg_data[SETB_W-1:0];
                REG_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFFB_W-1:0];
                REG_WAYS_IN_USE: r_ways        <= i_cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_ways == '0) begin
            ways_act = WAYC_W'(1);
        end else if (WAYC_W'(r_ways) > WAYC_W'(MAX_WAYS)) begin
            ways_act = WAYC_W'(MAX_WAYS);
        end else begin
            ways_act = WAYC_W'(r_ways);
        end
    end

    // split the address; the set index folds onto the sets present
    always_comb begin
        req_block = i_req.address >> r_offset_bits;
        for (int b = 0; b < SET_W; b++) begin
            set_mask[b] = (SETB_W'(b) < r_set_bits);
        end
        req_set = req_block[SET_W-1:0] & set_mask;
    end

    assign s1_adv      = !r_out_valid || o_rsp.ready;
    assign s1_fire     = r_s1_valid && s1_adv;
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign req_acc     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1_mode  <= i_req.mode;
            r_s1_block <= req_block;
            r_s1_set   <= req_set;
        end
    end

    assign fill = s1_fire && !m.hit;

    for (genvar w = 0; w < MAX_WAYS; w++) begin : g_tag
        sacl_ram #(
            .WIDTH (ADDR_W),
            .DEPTH (MAX_SETS)
        ) u_tag_ram (
            .i_clk   (i_clk),
            .i_we    (fill && (m.way == WAY_W'(w))),
            .i_waddr (r_s1_set),
            .i_wdata (r_s1_block),
            .i_re    (req_acc),
            .i_raddr (req_set),
            .o_rdata (tag_rd[w])
        );
    end

    sacl_ram #(
        .WIDTH ($bits(t_meta)),
        .DEPTH (MAX_SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (fill),
        .i_waddr (r_s1_set),
        .i_wdata (m.meta_next),
        .i_re    (req_acc),
        .i_raddr (req_set),
        .o_rdata (meta_rd)
    );

    // the fill made on the edge of the read is not in the read data: bypass it
    assign fw_hit = r_fw_valid && (r_fw_set == r_s1_set);

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            tag_eff[w] = (fw_hit && (r_fw_way == WAY_W'(w))) ? r_fw_tag : tag_rd[w];
        end
        if (fw_hit) begin
            meta_eff = r_fw_meta;
        end else if (r_touched[r_s1_set]) begin
            meta_eff = meta_rd;
        end else begin
            meta_eff = '0;
        end
    end

    sacl_match u_match (
        .i_block (r_s1_block),
        .i_ways  (ways_act),
        .i_tags  (tag_eff),
        .i_meta  (meta_eff),
        .o_match (m)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
            r_touched  <= '0;
        end else if (fill) begin
            r_fw_valid          <= 1'b1;
            r_touched[r_s1_set] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill) begin
            r_fw_set  <= r_s1_set;
            r_fw_way  <= m.way;
            r_fw_tag  <= r_s1_block;
            r_fw_meta <= m.meta_next;
        end
    end

    always_comb begin
        if (m.hit) begin
            n_outcome = (r_s1_mode == MODE_WRITE) ? OC_WRITE_HIT : OC_READ_HIT;
        end else begin
            n_outcome = (r_s1_mode == MODE_WRITE) ? OC_WRITE_MISS : OC_READ_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_outcome <= n_outcome;
            r_out_way     <= OUTWAY_W'(m.way);
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.outcome  = r_out_outcome;
    assign o_rsp.way_used = r_out_way;

`ifndef SYNTH
    a_fill_marks_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill |=> r_touched[$past(r_s1_set)])
        else $error("filled set not marked as touched");

    a_way_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |-> (WAYC_W'(m.way) < ways_act))
        else $error("reported way outside the ways in use");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> r_s1_valid)
        else $error("accepted request lost before compare stage");
`endif

endmodule
`default_nettype wire

/* hw/rtl/sacl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sacl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sacl_match.sv */
// Tag compare across the ways of one set, and victim choice on a miss.
`default_nettype none
module sacl_match (
    input  wire logic                     [sacl_pkg::ADDR_W-1:0] i_block,
    input  wire logic                     [sacl_pkg::WAYC_W-1:0] i_ways,
    input  wire sacl_pkg::t_tag_arr                              i_tags,
    input  wire sacl_pkg::t_meta                                 i_meta,
    output sacl_pkg::t_match                                     o_match
);
    import sacl_pkg::*;

    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
    logic [WAYC_W:0]  victim_inc;

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        // scan downwards so the lowest matching way wins
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (i_meta.valid[w] && (WAYC_W'(w) < i_ways) && (i_tags[w] == i_block)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        // pointer left stale by a smaller way count falls back to way zero
        victim     = ({1'b0, i_meta.ptr} >= i_ways) ? '0 : i_meta.ptr;
        victim_inc = (WAYC_W + 1)'(victim) + (WAYC_W + 1)'(1);

        o_match.hit                 = hit;
        o_match.way                 = hit ? hit_way : victim;
        o_match.meta_next.valid     = i_meta.valid | (MAX_WAYS'(1) << victim);
        o_match.meta_next.ptr       = (victim_inc < (WAYC_W + 1)'(i_ways))
                                    ? WAY_W'(victim_inc) : '0;
    end

endmodule
`default_nettype wire
